// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while reset is asserted.
`define ASSERT_CLKD(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that is checked in reset too.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ledb_pkg.sv
package ledb_pkg;

	localparam int CFG_W   = 16;
	localparam int LEVEL_W = 17;
	localparam int IDX_W   = 3;

	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 17'h10000;

	// Register indexes of the configuration port
	localparam logic [IDX_W-1:0] REG_ATTACK = 3'd0;
	localparam logic [IDX_W-1:0] REG_DECAY  = 3'd1;
	localparam logic [IDX_W-1:0] REG_ON     = 3'd2;
	localparam logic [IDX_W-1:0] REG_GAP    = 3'd3;
	localparam logic [IDX_W-1:0] REG_COUNT  = 3'd4;

	localparam logic [15:0] ATTACK_RST = 16'd10;
	localparam logic [15:0] DECAY_RST  = 16'd200;
	localparam logic [15:0] ON_RST     = 16'd80;
	localparam logic [15:0] GAP_RST    = 16'd80;
	localparam logic [7:0]  COUNT_RST  = 8'd2;

	typedef enum logic [1:0] {
		KIND_RESET = 2'd0,
		KIND_FIRE  = 2'd1,
		KIND_PULSE = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE  = 2'd0,
		MODE_ENV   = 2'd1,
		MODE_BLINK = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_ZERO,
		PH_ATTACK,
		PH_DECAY,
		PH_BLINK
	} phase_t;

	typedef struct packed {
		logic take;
		logic setup;
		logic step;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic skip;
		logic div_last;
	} status_t;

endpackage

// File: design/led_envelope_and_blink.sv
// Channel  Handshake                  Payload
// cmd      cmd_valid / cmd_ready      kind[1:0], now_ms[31:0]
// level    level_valid / level_ready  brightness[16:0]
// cfg      cfg_we (no wait)           cfg_index[2:0], cfg_data[15:0]
//
// Reset, fire and pulse beats are taken in the idle state and start no query.
// A query passes setup, check, the divider and finish: 16 divider steps in the envelope,
// 25 in blink; a dark answer goes from check straight to finish.
// The divider is a shared restoring unit that retires one quotient bit per cycle.
// The result register frees the command side; a stalled level beat holds the
// next query in its last cycle. Reset is asynchronous and clears all control state.
module led_envelope_and_blink #(
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ledb_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ledb_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  logic [1:0]                    kind,
	input  logic [31:0]                   now_ms,
	output logic                          level_valid,
	input  logic                          level_ready,
	output logic [ledb_pkg::LEVEL_W-1:0]  brightness
);

	ledb_pkg::cmd_t    cmd;
	ledb_pkg::status_t sts;

	ledb_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.kind        (kind),
		.level_ready (level_ready),
		.sts         (sts),
		.cmd_ready   (cmd_ready),
		.level_valid (level_valid),
		.cmd         (cmd)
	);

	ledb_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kind       (kind),
		.now_ms     (now_ms),
		.cmd        (cmd),
		.sts        (sts),
		.brightness (brightness)
	);

endmodule

// File: design/ledb_dp.sv
module ledb_dp #(
	parameter int TIME_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ledb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ledb_pkg::CFG_W-1:0]        cfg_data,
	input  logic [1:0]                        kind,
	input  logic [31:0]                       now_ms,
	input  ledb_pkg::cmd_t                    cmd,
	output ledb_pkg::status_t                 sts,
	output logic [ledb_pkg::LEVEL_W-1:0]      brightness
);

	localparam int CW = (TIME_BITS > 25) ? TIME_BITS : 25;

	logic [15:0] attack_q, decay_q, on_q, gap_q;
	logic [7:0]  count_q;
	ledb_pkg::mode_t mode_q;
	logic [TIME_BITS-1:0] start_q;

	logic [TIME_BITS-1:0] now_w, e_q, d_w;
	logic                 early_q;
	ledb_pkg::phase_t     phase_q, phase_w;
	logic [17:0]          rem_q, t_w;
	logic [24:0]          dvd_q;
	logic [15:0]          quo_q;
	logic [16:0]          den_q, unit_w;
	logic [4:0]           cnt_q;
	logic [24:0]          total_q, prod_w;
	logic                 ge_w, in_att_w, in_dec_w, skip_w;
	logic [ledb_pkg::LEVEL_W-1:0] level_w, brightness_q;

	assign now_w    = TIME_BITS'(now_ms);
	assign d_w      = e_q - TIME_BITS'(attack_q);
	assign in_att_w = e_q < TIME_BITS'(attack_q);
	assign in_dec_w = d_w < TIME_BITS'(decay_q);
	assign unit_w   = {1'b0, on_q} + {1'b0, gap_q};
	assign prod_w   = {17'b0, count_q} * {8'b0, unit_w};

	always_comb begin
		phase_w = ledb_pkg::PH_ZERO;
		if (!early_q) begin
			case (mode_q)
				ledb_pkg::MODE_ENV: begin
					if (in_att_w)
						phase_w = ledb_pkg::PH_ATTACK;
					else if (in_dec_w)
						phase_w = ledb_pkg::PH_DECAY;
				end
				ledb_pkg::MODE_BLINK: phase_w = ledb_pkg::PH_BLINK;
				default:              phase_w = ledb_pkg::PH_ZERO;
			endcase
		end
	end

	// Configuration and command state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q <= ledb_pkg::ATTACK_RST;
			decay_q  <= ledb_pkg::DECAY_RST;
			on_q     <= ledb_pkg::ON_RST;
			gap_q    <= ledb_pkg::GAP_RST;
			count_q  <= ledb_pkg::COUNT_RST;
			mode_q   <= ledb_pkg::MODE_IDLE;
			start_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					ledb_pkg::REG_ATTACK: attack_q <= cfg_data;
					ledb_pkg::REG_DECAY:  decay_q  <= cfg_data;
					ledb_pkg::REG_ON:     on_q     <= cfg_data;
					ledb_pkg::REG_GAP:    gap_q    <= cfg_data;
					ledb_pkg::REG_COUNT:  count_q  <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (cmd.take) begin
				unique case (ledb_pkg::kind_t'(kind))
					ledb_pkg::KIND_RESET: begin
						mode_q  <= ledb_pkg::MODE_IDLE;
						start_q <= '0;
					end
					ledb_pkg::KIND_FIRE: begin
						mode_q  <= ledb_pkg::MODE_ENV;
						start_q <= now_w;
					end
					ledb_pkg::KIND_PULSE: begin
						mode_q  <= ledb_pkg::MODE_BLINK;
						start_q <= now_w;
					end
					ledb_pkg::KIND_QUERY: ;
				endcase
			end
		end
	end

	// Restoring divider step: one quotient bit per cycle
	assign t_w  = {rem_q[16:0], dvd_q[24]};
	assign ge_w = t_w >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			e_q     <= now_w - start_q;
			early_q <= now_w < start_q;
		end
		if (cmd.setup) begin
			phase_q <= phase_w;
			total_q <= prod_w;
			quo_q   <= '0;
			case (phase_w)
				ledb_pkg::PH_ATTACK: begin
					rem_q <= 18'(e_q[15:0]);
					dvd_q <= '0;
					den_q <= {1'b0, attack_q};
					cnt_q <= 5'd16;
				end
				ledb_pkg::PH_DECAY: begin
					rem_q <= 18'(d_w[15:0]);
					dvd_q <= '0;
					den_q <= {1'b0, decay_q};
					cnt_q <= 5'd16;
				end
				default: begin
					rem_q <= '0;
					dvd_q <= 25'(e_q);
					den_q <= unit_w;
					cnt_q <= 5'd25;
				end
			endcase
		end
		if (cmd.step) begin
			rem_q <= ge_w ? (t_w - {1'b0, den_q}) : t_w;
			dvd_q <= {dvd_q[23:0], 1'b0};
			quo_q <= {quo_q[14:0], ge_w};
			cnt_q <= cnt_q - 5'd1;
		end
		if (cmd.load)
			brightness_q <= level_w;
	end

	// A zero phase, or a blink past the end of the pattern, counts as dark
	assign skip_w = (phase_q == ledb_pkg::PH_ZERO) ||
		((phase_q == ledb_pkg::PH_BLINK) && (CW'(e_q) >= CW'(total_q)));

	always_comb begin
		case (phase_q)
			ledb_pkg::PH_ATTACK: level_w = {1'b0, quo_q};
			ledb_pkg::PH_DECAY:  level_w = ledb_pkg::FULL_LEVEL - {1'b0, quo_q};
			ledb_pkg::PH_BLINK:
				level_w = (rem_q < {2'b0, on_q}) ? ledb_pkg::FULL_LEVEL : '0;
			default:             level_w = '0;
		endcase
		if (skip_w)
			level_w = '0;
	end

	assign sts.skip     = skip_w;
	assign sts.div_last = (cnt_q == 5'd1);
	assign brightness   = brightness_q;

endmodule

// File: design/ledb_ctrl.sv
module ledb_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  logic [1:0]         kind,
	input  logic               level_ready,
	input  ledb_pkg::status_t  sts,
	output logic               cmd_ready,
	output logic               level_valid,
	output ledb_pkg::cmd_t     cmd
);

	ledb_pkg::state_t state_q, state_nx;
	logic             out_valid_q;
	logic             out_free_w;

	assign out_free_w = !out_valid_q || level_ready;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ledb_pkg::ST_IDLE:
				if (cmd_valid && (ledb_pkg::kind_t'(kind) == ledb_pkg::KIND_QUERY))
					state_nx = ledb_pkg::ST_SETUP;
			ledb_pkg::ST_SETUP:  state_nx = ledb_pkg::ST_CHECK;
			ledb_pkg::ST_CHECK:  state_nx = sts.skip ? ledb_pkg::ST_FINISH : ledb_pkg::ST_DIV;
			ledb_pkg::ST_DIV:
				if (sts.div_last)
					state_nx = ledb_pkg::ST_FINISH;
			ledb_pkg::ST_FINISH:
				if (out_free_w)
					state_nx = ledb_pkg::ST_IDLE;
			default: state_nx = ledb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = (state_q == ledb_pkg::ST_IDLE);
		cmd.take  = (state_q == ledb_pkg::ST_IDLE) && cmd_valid;
		cmd.setup = (state_q == ledb_pkg::ST_SETUP);
		cmd.step  = (state_q == ledb_pkg::ST_DIV);
		cmd.load  = (state_q == ledb_pkg::ST_FINISH) && out_free_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ledb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			// hold the result until its beat is taken
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (level_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign level_valid = out_valid_q;

endmodule

// File: design/ledb_chk.sv
`include "assert_macros.svh"

module ledb_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_valid,
	input logic        cmd_ready,
	input logic [1:0]  kind,
	input logic        level_valid,
	input logic        level_ready,
	input logic [16:0] brightness
);

	logic query_beat, other_beat;

	assign query_beat = cmd_valid && cmd_ready && (kind == ledb_pkg::KIND_QUERY);
	assign other_beat = cmd_valid && cmd_ready && (kind != ledb_pkg::KIND_QUERY);

	`ASSERT_CLKD(a_level_hold, clk, arst_n, level_valid && !level_ready |=> level_valid && $stable(brightness), "stalled level beat changed")
	`ASSERT_CLKD(a_query_busy, clk, arst_n, query_beat |=> !cmd_ready, "command taken while a query is in work")
	`ASSERT_CLKD(a_no_result_other, clk, arst_n, other_beat && !level_valid |=> !level_valid, "result without a query")
	`ASSERT_CLKD(a_query_latency, clk, arst_n, query_beat && !level_valid |=> !level_valid ##1 !level_valid, "query answered too early")
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !level_valid, "level valid during reset")

endmodule

bind led_envelope_and_blink ledb_chk u_ledb_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd_valid),
	.cmd_ready   (cmd_ready),
	.kind        (kind),
	.level_valid (level_valid),
	.level_ready (level_ready),
	.brightness  (brightness)
);

// File: test/tb_led_envelope_and_blink.sv
`timescale 1ns / 1ps

module tb_led_envelope_and_blink;
	import ledb_pkg::*;

	localparam int WATCHDOG_LIMIT  = 3000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int HOLD_CYCLES     = 400;
	localparam int PHASES          = 8;
	localparam int BEATS_PER_PHASE = 62;
	localparam int BURST_QUERIES   = 20;

	typedef struct packed {
		kind_t              op;
		logic [31:0]        stamp;
		logic               typed;
		logic [LEVEL_W-1:0] level;
	} cmd_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam cmd_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{KIND_QUERY, 32'd0,          1'b1, 17'd0},
		'{KIND_QUERY, 32'hFFFF_FFFF,  1'b1, 17'd0},
		'{KIND_FIRE,  32'd1000,       1'b0, 17'd0},
		'{KIND_QUERY, 32'd999,        1'b1, 17'd0},
		'{KIND_QUERY, 32'd1000,       1'b1, 17'd0},
		'{KIND_QUERY, 32'd1005,       1'b0, 17'd0},
		'{KIND_QUERY, 32'd1010,       1'b1, FULL_LEVEL},
		'{KIND_QUERY, 32'd1110,       1'b0, 17'd0},
		'{KIND_QUERY, 32'd1209,       1'b0, 17'd0},
		'{KIND_QUERY, 32'd1210,       1'b1, 17'd0},
		'{KIND_PULSE, 32'd2000,       1'b0, 17'd0},
		'{KIND_QUERY, 32'd2000,       1'b1, FULL_LEVEL},
		'{KIND_QUERY, 32'd2079,       1'b1, FULL_LEVEL},
		'{KIND_QUERY, 32'd2080,       1'b1, 17'd0},
		'{KIND_QUERY, 32'd2160,       1'b1, FULL_LEVEL},
		'{KIND_QUERY, 32'd2319,       1'b1, 17'd0},
		'{KIND_QUERY, 32'd2320,       1'b1, 17'd0},
		'{KIND_FIRE,  32'hFFFF_FFF0,  1'b0, 17'd0},
		'{KIND_QUERY, 32'hFFFF_FFFF,  1'b0, 17'd0},
		'{KIND_QUERY, 32'd0,          1'b1, 17'd0},
		'{KIND_RESET, 32'd5,          1'b0, 17'd0},
		'{KIND_QUERY, 32'd5,          1'b1, 17'd0},
		'{KIND_PULSE, 32'd0,          1'b0, 17'd0},
		'{KIND_QUERY, 32'd0,          1'b1, FULL_LEVEL},
		'{KIND_QUERY, 32'h7FFF_FFFF,  1'b1, 17'd0}
	};

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]   cfg_data;
	logic               cmd_valid;
	logic               cmd_ready;
	logic [1:0]         kind;
	logic [31:0]        now_ms;
	logic               level_valid;
	logic               level_ready;
	logic [LEVEL_W-1:0] brightness;

	// Mirror of the block's state and registers
	mode_t       lamp_mode;
	logic [31:0] lamp_start;
	logic [15:0] cfg_attack;
	logic [15:0] cfg_decay;
	logic [15:0] cfg_on;
	logic [15:0] cfg_gap;
	logic [7:0]  cfg_count;

	logic [LEVEL_W-1:0] levels_due [$];
	logic [LEVEL_W-1:0] level_want;
	int errors = 0;
	int levels_checked = 0;
	int beats_sent = 0;
	int settings_used = 1;
	int idle_cycles = 0;
	int hold_requests = 0;
	int hold_served = 0;
	bit steady_run = 1'b0;

	led_envelope_and_blink i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.kind        (kind),
		.now_ms      (now_ms),
		.level_valid (level_valid),
		.level_ready (level_ready),
		.brightness  (brightness)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [LEVEL_W-1:0] level_for(input logic [31:0] stamp);
		logic [63:0] e;
		logic [63:0] d;
		logic [63:0] unit;
		logic [63:0] total;
		if (lamp_mode != MODE_ENV && lamp_mode != MODE_BLINK)
			return '0;
		if (stamp < lamp_start)
			return '0;
		e = 64'(stamp);
		e = e - 64'(lamp_start);
		if (lamp_mode == MODE_ENV) begin
			if (e < 64'(cfg_attack))
				return LEVEL_W'((e << 16) / 64'(cfg_attack));
			d = e - 64'(cfg_attack);
			if (d < 64'(cfg_decay))
				return LEVEL_W'(64'h10000 - (d << 16) / 64'(cfg_decay));
			return '0;
		end
		unit = 64'(cfg_on);
		unit = unit + 64'(cfg_gap);
		total = unit * 64'(cfg_count);
		if (e >= total)
			return '0;
		return ((e % unit) < 64'(cfg_on)) ? FULL_LEVEL : '0;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one command and hold it until the block takes it, then update the mirror.
	task automatic send_beat(input kind_t op, input logic [31:0] stamp,
			input logic typed, input logic [LEVEL_W-1:0] typed_level);
		cmd_valid <= 1'b1;
		kind      <= op;
		now_ms    <= stamp;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		beats_sent++;
		case (op)
			KIND_RESET: begin
				lamp_mode  = MODE_IDLE;
				lamp_start = '0;
			end
			KIND_FIRE: begin
				lamp_mode  = MODE_ENV;
				lamp_start = stamp;
			end
			KIND_PULSE: begin
				lamp_mode  = MODE_BLINK;
				lamp_start = stamp;
			end
			default: levels_due.push_back(typed ? typed_level : level_for(stamp));
		endcase
	endtask

	task automatic sender_gap(input bit steady);
		int g;
		g = steady ? 0 : pick_gap();
		if (g > 0) begin
			cmd_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (levels_due.size() != 0)
			@(posedge clk);
		// non-query beats give no result; let the last one retire
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_settings(input logic [15:0] a, input logic [15:0] d,
			input logic [15:0] o, input logic [15:0] g, input logic [7:0] c);
		logic [7:0] junk;
		junk = 8'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= REG_ATTACK;
		cfg_data  <= a;
		@(posedge clk);
		cfg_index <= REG_DECAY;
		cfg_data  <= d;
		@(posedge clk);
		cfg_index <= REG_ON;
		cfg_data  <= o;
		@(posedge clk);
		cfg_index <= REG_GAP;
		cfg_data  <= g;
		@(posedge clk);
		// upper bits of the count write must be dropped
		cfg_index <= REG_COUNT;
		cfg_data  <= {junk, c};
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_attack = a;
		cfg_decay  = d;
		cfg_on     = o;
		cfg_gap    = g;
		cfg_count  = c;
		settings_used++;
	endtask

	task automatic next_random_beat(output kind_t op, output logic [31:0] stamp);
		int r;
		int r2;
		logic [63:0] span;
		logic [63:0] edge_at;
		logic [31:0] reach;
		case (lamp_mode)
			MODE_ENV: begin
				span    = 64'(cfg_attack) + 64'(cfg_decay);
				edge_at = 64'(cfg_attack);
			end
			MODE_BLINK: begin
				span    = (64'(cfg_on) + 64'(cfg_gap)) * 64'(cfg_count);
				edge_at = 64'(cfg_on);
			end
			default: begin
				span    = 64'd1000;
				edge_at = '0;
			end
		endcase
		reach = 32'(span + span / 4 + 64'd2);
		r  = $urandom_range(0, 99);
		r2 = $urandom_range(0, 99);
		if (r < 6) begin
			op    = KIND_RESET;
			stamp = $urandom;
		end else if (r < 36) begin
			op    = (r < 21) ? KIND_FIRE : KIND_PULSE;
			stamp = (r2 < 75) ? lamp_start + $urandom_range(0, 5000) : $urandom;
		end else begin
			op = KIND_QUERY;
			if (r2 < 60)
				stamp = lamp_start + $urandom_range(0, reach);
			else if (r2 < 78)
				stamp = lamp_start + 32'(($urandom_range(0, 1) ? span : edge_at))
					- $urandom_range(0, 1);
			else if (r2 < 90)
				stamp = lamp_start - $urandom_range(1, 100);
			else
				stamp = $urandom;
		end
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin : level_sink
		int run;
		int g;
		forever begin
			if (hold_served != hold_requests) begin
				hold_served <= hold_requests;
				level_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				level_ready <= 1'b1;
				run = steady_run ? 20 : $urandom_range(1, 8);
				repeat (run) @(posedge clk);
				g = steady_run ? 0 : pick_gap();
				if (g > 0) begin
					level_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && level_valid && level_ready) begin
			if (levels_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected brightness beat, expected none, got %0d",
					$time, brightness);
			end else begin
				level_want = levels_due.pop_front();
				levels_checked++;
				if (brightness !== level_want) begin
					errors++;
					$display("%0t: brightness mismatch, expected %0d, got %0d",
						$time, level_want, brightness);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (level_valid && level_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles, %0d results outstanding",
				$time, idle_cycles, levels_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		kind_t       op;
		logic [31:0] stamp;
		logic [15:0] ra;
		logic [15:0] rd;
		logic [15:0] ro;
		logic [15:0] rg;
		logic [7:0]  rc;
		bit          steady;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		cmd_valid   = 1'b0;
		kind        = '0;
		now_ms      = '0;
		level_ready = 1'b0;
		lamp_mode   = MODE_IDLE;
		lamp_start  = '0;
		cfg_attack  = ATTACK_RST;
		cfg_decay   = DECAY_RST;
		cfg_on      = ON_RST;
		cfg_gap     = GAP_RST;
		cfg_count   = COUNT_RST;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			send_beat(DIRECTED[i].op, DIRECTED[i].stamp, DIRECTED[i].typed,
				DIRECTED[i].level);
			sender_gap(1'b0);
		end
		drain();

		for (int p = 1; p <= PHASES; p++) begin
			case (p)
				1: load_settings(ATTACK_RST, DECAY_RST, ON_RST, GAP_RST, COUNT_RST);
				2: load_settings(16'd0, 16'd300, 16'd0, 16'd50, 8'd3);
				3: load_settings(16'd40, 16'd0, 16'd30, 16'd0, 8'd0);
				4: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
				5: load_settings(16'd1, 16'd1, 16'd1, 16'd1, 8'd1);
				6: begin
					ra = 16'($urandom_range(0, 300));
					rd = 16'($urandom_range(0, 300));
					ro = 16'($urandom_range(0, 100));
					rg = 16'($urandom_range(0, 100));
					rc = 8'($urandom_range(0, 6));
					load_settings(ra, rd, ro, rg, rc);
				end
				7: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
				default: begin
					ra = 16'($urandom);
					rd = 16'($urandom);
					ro = 16'($urandom);
					rg = 16'($urandom);
					rc = 8'($urandom);
					load_settings(ra, rd, ro, rg, rc);
				end
			endcase
			steady = (p == 3);
			steady_run <= steady;
			for (int i = 0; i < BEATS_PER_PHASE; i++) begin
				if (p == 2 && i == 10) begin
					// stall the result side while queries keep coming
					hold_requests <= hold_requests + 1;
					for (int j = 0; j < BURST_QUERIES; j++)
						send_beat(KIND_QUERY, lamp_start + j, 1'b0, '0);
				end
				if (p == 5 && i == 30)
					drain();
				next_random_beat(op, stamp);
				send_beat(op, stamp, 1'b0, '0);
				sender_gap(steady);
			end
			drain();
		end

		$display("Sent %0d commands, checked %0d brightness levels over %0d register settings,",
			beats_sent, levels_checked, settings_used);
		$display("including zero, unit and full-scale lengths and counts.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: led_envelope_and_blink.f
+incdir+design
design/ledb_pkg.sv
design/ledb_dp.sv
design/ledb_ctrl.sv
design/led_envelope_and_blink.sv
design/ledb_chk.sv
test/tb_led_envelope_and_blink.sv
